// File: design/clp_pkg.sv
// ----------------------------------------------------------------------------
// clp_pkg: shared types and constants for the CPU list text parser
// Character codes, the character classifier and the per-part result record.
// ----------------------------------------------------------------------------
package clp_pkg;

  localparam int CPU_OUT_BITS = 12;
  localparam int COUNT_BITS   = 16;

  localparam logic [CPU_OUT_BITS-1:0] CPU_OUT_MAX = '1;
  localparam logic [COUNT_BITS-1:0]   COUNT_MAX   = '1;

  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [3:0] DEC_BASE  = 4'd10;

  typedef enum logic [2:0] {
    CC_DIGIT,
    CC_HYPHEN,
    CC_COMMA,
    CC_TERM,
    CC_OTHER
  } char_class_t;

  typedef struct packed {
    logic [CPU_OUT_BITS-1:0] first_cpu;
    logic [CPU_OUT_BITS-1:0] last_cpu;
    logic                    part_is_range;
    logic [COUNT_BITS-1:0]   cpus_listed;
    logic                    format_error;
    logic                    end_of_line;
  } clp_part_t;

  function automatic char_class_t classify(input logic [7:0] ch);
    char_class_t cc;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      cc = CC_DIGIT;
    end else if (ch == CH_HYPHEN) begin
      cc = CC_HYPHEN;
    end else if (ch == CH_COMMA) begin
      cc = CC_COMMA;
    end else if (ch == CH_LF || ch == CH_CR || ch == CH_NUL) begin
      cc = CC_TERM;
    end else begin
      cc = CC_OTHER;
    end
    return cc;
  endfunction

endpackage

// File: design/cpu_list_text_parser.sv
// Path: a character that closes a part reaches the result ports through the
//   input register, then one pass of parsing logic, then the result register;
//   it waits in the input register while the result register is stalled.
// Throughput: one character per cycle, unless a closing character waits on a
//   stalled result; the parsing state is updated in that single pass of logic.
// Reset: synchronous, active low; clears the line state and both valid flags.
// ----------------------------------------------------------------------------
// cpu_list_text_parser: streaming parser for CPU list text such as 0-3,5,7-9
// Takes one ASCII character per transaction and emits one result transaction
// for every comma or line terminator.
// ----------------------------------------------------------------------------
module cpu_list_text_parser
  import clp_pkg::*;
#(
  parameter int MASK_BITS   = 64,
  parameter int NUMBER_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_character,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CPU_OUT_BITS-1:0] out_first_cpu,
  output logic [CPU_OUT_BITS-1:0] out_last_cpu,
  output logic                    out_part_is_range,
  output logic [MASK_BITS-1:0]    out_cpu_mask,
  output logic [COUNT_BITS-1:0]   out_cpus_listed,
  output logic                    out_format_error,
  output logic                    out_end_of_line
);

  logic                 held_valid;
  logic [7:0]           held_character;
  logic                 emits;
  logic                 space;
  logic                 advance;
  clp_part_t            part;
  logic [MASK_BITS-1:0] mask;

  // The held character moves on when it produces no result, or when the
  // result register is free or being emptied in this very cycle. Digits,
  // hyphens and stray bytes therefore never wait for the downstream side.
  assign advance = held_valid && (!emits || space);

  // Input register: decouples the upstream handshake from the parsing stage.
  clp_in_reg u_in_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_character   (in_character),
    .advance        (advance),
    .held_valid     (held_valid),
    .held_character (held_character)
  );

  // Parsing stage: the number accumulator, range start and per-line mask,
  // count and error flag live here and change only when a character advances.
  clp_parse_core #(
    .MASK_BITS   (MASK_BITS),
    .NUMBER_BITS (NUMBER_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .character (held_character),
    .emits     (emits),
    .part      (part),
    .mask      (mask)
  );

  // Result register: a finished part waits here while the next characters
  // keep flowing into the parsing stage.
  clp_out_reg #(
    .MASK_BITS (MASK_BITS)
  ) u_out_reg (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (advance && emits),
    .part              (part),
    .mask              (mask),
    .space             (space),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_first_cpu     (out_first_cpu),
    .out_last_cpu      (out_last_cpu),
    .out_part_is_range (out_part_is_range),
    .out_cpu_mask      (out_cpu_mask),
    .out_cpus_listed   (out_cpus_listed),
    .out_format_error  (out_format_error),
    .out_end_of_line   (out_end_of_line)
  );

  // A result-producing character must not advance while the result is stuck.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !(advance && emits))
    else $error("result register overwritten while stalled");

  // A held character that needs no result never blocks the input.
  a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid && !emits |-> in_ready)
    else $error("input stalled by a character that yields no result");

  // A stalled result with a closing character waiting holds the input back.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid && emits && out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while the parsing stage was blocked");

endmodule

// File: design/clp_in_reg.sv
// ----------------------------------------------------------------------------
// clp_in_reg: input register of the CPU list text parser
// Holds one accepted character until the parsing stage consumes it.
// ----------------------------------------------------------------------------
module clp_in_reg
  import clp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_character,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_character
);

  logic       valid_r;
  logic [7:0] char_r;

  // The register frees up in the same cycle as its content moves on.
  assign in_ready       = !valid_r || advance;
  assign held_valid     = valid_r;
  assign held_character = char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_character;
    end
  end

endmodule

// File: design/clp_parse_core.sv
// ----------------------------------------------------------------------------
// clp_parse_core: parsing state and per-character update
// Accumulates numbers, tracks ranges and builds the result of a closed part.
// ----------------------------------------------------------------------------
module clp_parse_core
  import clp_pkg::*;
#(
  parameter int MASK_BITS   = 64,
  parameter int NUMBER_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           character,
  output logic                 emits,
  output clp_part_t            part,
  output logic [MASK_BITS-1:0] mask
);

  localparam int PROD_BITS = NUMBER_BITS + 4;
  localparam int SPAN_BITS = NUMBER_BITS + 1;
  localparam int SUM_BITS  = COUNT_BITS + 2;

  logic [NUMBER_BITS-1:0] acc_r, acc_nxt;
  logic [NUMBER_BITS-1:0] start_r, start_nxt;
  logic                   hyphen_r, hyphen_nxt;
  logic [MASK_BITS-1:0]   mask_r, mask_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic                   err_r, err_nxt;

  char_class_t            cc;
  logic [PROD_BITS-1:0]   prod;
  logic                   ovf;
  logic [NUMBER_BITS-1:0] first, last;
  logic                   in_order;
  logic [SPAN_BITS-1:0]   span;
  logic [SUM_BITS-1:0]    sum;
  logic [COUNT_BITS-1:0]  count_close;
  logic [MASK_BITS-1:0]   part_bits;
  logic [MASK_BITS-1:0]   mask_close;
  logic                   beyond;
  logic                   err_close;

  function automatic logic [CPU_OUT_BITS-1:0] sat_cpu(input logic [NUMBER_BITS-1:0] v);
    logic [15:0] w;
    w = 16'(v);
    return (w > 16'(CPU_OUT_MAX)) ? CPU_OUT_MAX : w[CPU_OUT_BITS-1:0];
  endfunction

  assign cc    = classify(character);
  assign emits = (cc == CC_COMMA) || (cc == CC_TERM);

  // Decimal accumulate; any carry beyond the number width saturates.
  assign prod = PROD_BITS'(acc_r) * PROD_BITS'(DEC_BASE) + PROD_BITS'(character[3:0]);
  assign ovf  = |prod[PROD_BITS-1:NUMBER_BITS];

  assign first    = hyphen_r ? start_r : acc_r;
  assign last     = hyphen_r ? acc_r : first;
  assign in_order = first <= last;

  assign span = SPAN_BITS'(last) - SPAN_BITS'(first) + SPAN_BITS'(1);
  assign sum  = SUM_BITS'(count_r) + SUM_BITS'(span);

  always_comb begin
    if (!in_order) begin
      count_close = count_r;
    end else if (sum > SUM_BITS'(COUNT_MAX)) begin
      count_close = COUNT_MAX;
    end else begin
      count_close = sum[COUNT_BITS-1:0];
    end
  end

  // One comparator pair per mask bit: set when the bit lies inside the range.
  always_comb begin
    for (int i = 0; i < MASK_BITS; i++) begin
      part_bits[i] = in_order && (NUMBER_BITS'(i) >= first) && (NUMBER_BITS'(i) <= last);
    end
  end

  assign mask_close = mask_r | part_bits;
  assign beyond     = in_order && (32'(last) >= 32'(MASK_BITS));
  assign err_close  = err_r || beyond;

  assign part.first_cpu     = sat_cpu(first);
  assign part.last_cpu      = sat_cpu(last);
  assign part.part_is_range = hyphen_r;
  assign part.cpus_listed   = count_close;
  assign part.format_error  = err_close;
  assign part.end_of_line   = (cc == CC_TERM);
  assign mask               = mask_close;

  always_comb begin
    acc_nxt    = acc_r;
    start_nxt  = start_r;
    hyphen_nxt = hyphen_r;
    mask_nxt   = mask_r;
    count_nxt  = count_r;
    err_nxt    = err_r;
    case (cc)
      CC_DIGIT: begin
        acc_nxt = ovf ? '1 : prod[NUMBER_BITS-1:0];
        err_nxt = err_r || ovf;
      end
      CC_HYPHEN: begin
        err_nxt    = err_r || hyphen_r;
        start_nxt  = acc_r;
        acc_nxt    = '0;
        hyphen_nxt = 1'b1;
      end
      CC_COMMA: begin
        acc_nxt    = '0;
        start_nxt  = '0;
        hyphen_nxt = 1'b0;
        mask_nxt   = mask_close;
        count_nxt  = count_close;
        err_nxt    = err_close;
      end
      CC_TERM: begin
        acc_nxt    = '0;
        start_nxt  = '0;
        hyphen_nxt = 1'b0;
        mask_nxt   = '0;
        count_nxt  = '0;
        err_nxt    = 1'b0;
      end
      default: begin
        err_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      start_r  <= '0;
      hyphen_r <= 1'b0;
      mask_r   <= '0;
      count_r  <= '0;
      err_r    <= 1'b0;
    end else if (step) begin
      acc_r    <= acc_nxt;
      start_r  <= start_nxt;
      hyphen_r <= hyphen_nxt;
      mask_r   <= mask_nxt;
      count_r  <= count_nxt;
      err_r    <= err_nxt;
    end
  end

  // A terminator leaves a clean line behind it.
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && (cc == CC_TERM) |=> (count_r == '0) && (mask_r == '0) && !err_r && !hyphen_r)
    else $error("line state not cleared after terminator");

  // Within a line the entry count never falls.
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !(step && (cc == CC_TERM)) |=> count_r >= $past(count_r))
    else $error("entry count decreased within a line");

  // The error flag is sticky until a terminator.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r && !(step && (cc == CC_TERM)) |=> err_r)
    else $error("error flag dropped within a line");

  // A closed part's mask always covers the line's earlier mask.
  a_mask_grows: assert property (@(posedge clk) disable iff (!rst_n)
    step && emits |-> ((mask & mask_r) == mask_r))
    else $error("result mask lost earlier bits");

endmodule

// File: design/clp_out_reg.sv
// ----------------------------------------------------------------------------
// clp_out_reg: result register of the CPU list text parser
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module clp_out_reg
  import clp_pkg::*;
#(
  parameter int MASK_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  clp_part_t               part,
  input  logic [MASK_BITS-1:0]    mask,
  output logic                    space,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [CPU_OUT_BITS-1:0] out_first_cpu,
  output logic [CPU_OUT_BITS-1:0] out_last_cpu,
  output logic                    out_part_is_range,
  output logic [MASK_BITS-1:0]    out_cpu_mask,
  output logic [COUNT_BITS-1:0]   out_cpus_listed,
  output logic                    out_format_error,
  output logic                    out_end_of_line
);

  logic                 valid_r;
  clp_part_t            part_r;
  logic [MASK_BITS-1:0] mask_r;

  assign space = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && space) begin
      part_r <= part;
      mask_r <= mask;
    end
  end

  assign out_valid         = valid_r;
  assign out_first_cpu     = part_r.first_cpu;
  assign out_last_cpu      = part_r.last_cpu;
  assign out_part_is_range = part_r.part_is_range;
  assign out_cpu_mask      = mask_r;
  assign out_cpus_listed   = part_r.cpus_listed;
  assign out_format_error  = part_r.format_error;
  assign out_end_of_line   = part_r.end_of_line;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CPU list text parser
// Feeds CPU list text one character per transaction: a short table of
// hand-picked rows first, then randomly built lines (mostly well formed, the
// rest noise) under several patterns of sender idling and receiver stalling.
// Every result transaction is compared field by field against the hand-typed
// report of a fixed table row or else a behavioural parser model in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import clp_pkg::*;

  localparam int MASK_BITS      = 64;
  localparam int NUMBER_BITS    = 12;
  localparam int NUM_LIMIT      = (1 << NUMBER_BITS) - 1;
  localparam int PHASE_CHARS    = 250;
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 5000;

  // One closed part as the block reports it.
  typedef struct packed {
    logic [CPU_OUT_BITS-1:0] first_cpu;
    logic [CPU_OUT_BITS-1:0] last_cpu;
    logic                    part_is_range;
    logic [MASK_BITS-1:0]    cpu_mask;
    logic [COUNT_BITS-1:0]   cpus_listed;
    logic                    format_error;
    logic                    end_of_line;
  } part_report_t;

  // One row of the directed table. Where fixed is set, want is the report
  // that the character must produce, typed in by hand; otherwise the model
  // decides.
  typedef struct packed {
    logic [7:0]   ch;
    logic         fixed;
    part_report_t want;
  } stim_row_t;

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic [7:0]              in_character = CH_NUL;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic [CPU_OUT_BITS-1:0] out_first_cpu;
  logic [CPU_OUT_BITS-1:0] out_last_cpu;
  logic                    out_part_is_range;
  logic [MASK_BITS-1:0]    out_cpu_mask;
  logic [COUNT_BITS-1:0]   out_cpus_listed;
  logic                    out_format_error;
  logic                    out_end_of_line;

  // Side-band copy of the directed row, held alongside the character so that
  // the scoreboard sees it in the very cycle the transaction is accepted.
  logic         in_fixed      = 1'b0;
  part_report_t in_fixed_want = '0;

  // Parser model state: the part being assembled and the line so far.
  logic [NUMBER_BITS-1:0] pend_number  = '0;
  logic [NUMBER_BITS-1:0] pend_start   = '0;
  logic                   pend_hyphen  = 1'b0;
  logic [MASK_BITS-1:0]   line_cpus    = '0;
  logic [COUNT_BITS-1:0]  line_entries = '0;
  logic                   line_error   = 1'b0;

  part_report_t part_reports[$];
  int unsigned  mismatches    = 0;
  int unsigned  chars_sent    = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;

  // Idling pattern per random phase: none, sender only, receiver only, both.
  int unsigned phase_send_idle[4]  = '{0, 82, 0, 33};
  int unsigned phase_recv_stall[4] = '{0, 0, 82, 33};

  // The directed table covers an empty part ended by a newline, a plain
  // range, number overflow together with a CPU far beyond the mask, a
  // reversed range, and a part with a second hyphen, a CPU just past the
  // mask and a stray byte, ended by NUL.
  stim_row_t directed_rows [24] = '{
    '{CH_LF,     1'b1, '{12'd0, 12'd0, 1'b0, 64'h1, 16'd1, 1'b0, 1'b1}},
    '{"0",       1'b0, '0},
    '{CH_HYPHEN, 1'b0, '0},
    '{"3",       1'b0, '0},
    '{CH_COMMA,  1'b1, '{12'd0, 12'd3, 1'b1, 64'hF, 16'd4, 1'b0, 1'b0}},
    '{"9",       1'b0, '0},
    '{"9",       1'b0, '0},
    '{"9",       1'b0, '0},
    '{"9",       1'b0, '0},
    '{"9",       1'b0, '0},
    '{CH_CR,     1'b1, '{12'd4095, 12'd4095, 1'b0, 64'hF, 16'd5, 1'b1, 1'b1}},
    '{"5",       1'b0, '0},
    '{CH_HYPHEN, 1'b0, '0},
    '{"2",       1'b0, '0},
    '{CH_COMMA,  1'b1, '{12'd5, 12'd2, 1'b1, 64'h0, 16'd0, 1'b0, 1'b0}},
    '{"6",       1'b0, '0},
    '{"3",       1'b0, '0},
    '{CH_HYPHEN, 1'b0, '0},
    '{"7",       1'b0, '0},
    '{CH_HYPHEN, 1'b0, '0},
    '{"6",       1'b0, '0},
    '{"4",       1'b0, '0},
    '{8'hFF,     1'b0, '0},
    '{CH_NUL,    1'b1,
      '{12'd7, 12'd64, 1'b1, 64'hFFFF_FFFF_FFFF_FF80, 16'd58, 1'b1, 1'b1}}
  };

  cpu_list_text_parser #(
    .MASK_BITS   (MASK_BITS),
    .NUMBER_BITS (NUMBER_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_character      (in_character),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_cpu     (out_first_cpu),
    .out_last_cpu      (out_last_cpu),
    .out_part_is_range (out_part_is_range),
    .out_cpu_mask      (out_cpu_mask),
    .out_cpus_listed   (out_cpus_listed),
    .out_format_error  (out_format_error),
    .out_end_of_line   (out_end_of_line)
  );

  always #5 clk = ~clk;

  // The receiver decides afresh every cycle whether to take a result.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Parser model: consumes one character and, for a comma or a terminator,
  // hands back the report of the part that the character closes.
  task automatic parse_char(input logic [7:0] ch, output bit closes,
                            output part_report_t rep);
    int unsigned value;
    int unsigned lo;
    int unsigned hi;
    int unsigned total;
    closes = 1'b0;
    rep    = '0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      // Decimal accumulate; a number that outgrows the accumulator sticks
      // at its top value and marks the line as malformed.
      value = 32'(pend_number) * DEC_BASE + 32'(ch - CH_ZERO);
      if (value > NUM_LIMIT) begin
        value      = NUM_LIMIT;
        line_error = 1'b1;
      end
      pend_number = value[NUMBER_BITS-1:0];
    end else if (ch == CH_HYPHEN) begin
      // A second hyphen is an error, but the latest number still becomes
      // the start of the range.
      if (pend_hyphen) begin
        line_error = 1'b1;
      end
      pend_start  = pend_number;
      pend_number = '0;
      pend_hyphen = 1'b1;
    end else if (ch == CH_COMMA || ch == CH_LF || ch == CH_CR || ch == CH_NUL) begin
      lo = pend_hyphen ? pend_start : pend_number;
      hi = pend_hyphen ? pend_number : lo;
      // A reversed range lists nothing and leaves count and mask alone.
      if (lo <= hi) begin
        total        = line_entries + (hi - lo + 1);
        line_entries = (total > COUNT_MAX) ? COUNT_MAX : total[COUNT_BITS-1:0];
        for (int unsigned n = lo; n <= hi && n < MASK_BITS; n++) begin
          line_cpus[n] = 1'b1;
        end
        if (hi >= MASK_BITS) begin
          line_error = 1'b1;
        end
      end
      closes            = 1'b1;
      rep.first_cpu     = (lo > CPU_OUT_MAX) ? CPU_OUT_MAX : lo[CPU_OUT_BITS-1:0];
      rep.last_cpu      = (hi > CPU_OUT_MAX) ? CPU_OUT_MAX : hi[CPU_OUT_BITS-1:0];
      rep.part_is_range = pend_hyphen;
      rep.cpu_mask      = line_cpus;
      rep.cpus_listed   = line_entries;
      rep.format_error  = line_error;
      rep.end_of_line   = (ch != CH_COMMA);
      pend_number       = '0;
      pend_start        = '0;
      pend_hyphen       = 1'b0;
      // A terminator also forgets everything the line had gathered.
      if (ch != CH_COMMA) begin
        line_cpus    = '0;
        line_entries = '0;
        line_error   = 1'b0;
      end
    end else begin
      line_error = 1'b1;
    end
  endtask

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Scoreboard. Both channels are looked at in one process, results first,
  // so the order of pops and pushes is always the same.
  always @(posedge clk) begin : scoreboard
    part_report_t want;
    part_report_t rep;
    bit           closes;
    if (rst_n && out_valid && out_ready) begin
      if (part_reports.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual first %0d last %0d",
                 $time, out_first_cpu, out_last_cpu);
        mismatches++;
      end else begin
        want = part_reports.pop_front();
        check_field("first_cpu", want.first_cpu, out_first_cpu);
        check_field("last_cpu", want.last_cpu, out_last_cpu);
        check_field("part_is_range", want.part_is_range, out_part_is_range);
        check_field("cpu_mask", want.cpu_mask, out_cpu_mask);
        check_field("cpus_listed", want.cpus_listed, out_cpus_listed);
        check_field("format_error", want.format_error, out_format_error);
        check_field("end_of_line", want.end_of_line, out_end_of_line);
      end
    end
    if (rst_n && in_valid && in_ready) begin
      parse_char(in_character, closes, rep);
      if (closes) begin
        part_reports.push_back(in_fixed ? in_fixed_want : rep);
      end
    end
  end

  // Watchdog: any long stretch without a single transaction on either
  // channel means the block has hung or lost a result.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Offers one character and waits until it is taken. Idle cycles, if any,
  // come before valid is raised, so valid never drops while an offer stands.
  task automatic send_char(input logic [7:0] ch, input logic fixed,
                           input part_report_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_character  <= ch;
    in_fixed      <= fixed;
    in_fixed_want <= want;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    chars_sent++;
  endtask

  // Sends a decimal number; a negative value stands for a missing number.
  task automatic send_number(input int n);
    string digits;
    if (n >= 0) begin
      if ($urandom_range(99) < 5) begin
        send_char("0", 1'b0, '0);
      end
      digits = $sformatf("%0d", n);
      for (int i = 0; i < digits.len(); i++) begin
        send_char(digits[i], 1'b0, '0);
      end
    end
  endtask

  // Mostly CPUs close to the mask width, some anywhere in the output range,
  // a few that overflow the accumulator and a few that are left out.
  function automatic int pick_cpu();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) begin
      return -1;
    end else if (r < 70) begin
      return $urandom_range(0, 70);
    end else if (r < 90) begin
      return $urandom_range(0, 4095);
    end
    return $urandom_range(4096, 99999);
  endfunction

  task automatic send_random_line();
    int unsigned kind;
    int unsigned parts;
    int          lo;
    kind  = $urandom_range(99);
    parts = $urandom_range(1, 6);
    if (kind < 10) begin
      // Noise: arbitrary bytes, which may or may not end the line.
      repeat ($urandom_range(1, 10)) begin
        send_char(8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end else begin
      // Seventeen full-width ranges in one line push the entry count into
      // saturation.
      if (kind < 12) begin
        parts = 17;
      end
      for (int p = 0; p < parts; p++) begin
        if (kind < 12) begin
          send_number(0);
          send_char(CH_HYPHEN, 1'b0, '0);
          send_number(4095);
        end else if ($urandom_range(99) < 45) begin
          send_number(pick_cpu());
        end else begin
          lo = pick_cpu();
          send_number(lo);
          send_char(CH_HYPHEN, 1'b0, '0);
          // Three ranges in four run upwards; the rest may well be reversed.
          if (lo >= 0 && $urandom_range(3) != 0) begin
            send_number(lo + $urandom_range(0, 20));
          end else begin
            send_number(pick_cpu());
          end
          if ($urandom_range(99) < 8) begin
            send_char(CH_HYPHEN, 1'b0, '0);
            send_number(pick_cpu());
          end
        end
        if ($urandom_range(99) < 5) begin
          send_char(8'($urandom_range(0, 255)), 1'b0, '0);
        end
        if (p + 1 < parts) begin
          send_char(CH_COMMA, 1'b0, '0);
        end
      end
      case ($urandom_range(2))
        0: begin
          send_char(CH_LF, 1'b0, '0);
        end
        1: begin
          send_char(CH_CR, 1'b0, '0);
        end
        default: begin
          send_char(CH_NUL, 1'b0, '0);
        end
      endcase
    end
  endtask

  // Holds the sender back until every result owed has been collected.
  // The queue is looked at on the falling edge, clear of the scoreboard.
  task automatic drain_reports();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (part_reports.size() != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned target;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows with both sides running flat out.
    foreach (directed_rows[i]) begin
      send_char(directed_rows[i].ch, directed_rows[i].fixed, directed_rows[i].want);
    end
    drain_reports();

    // Random lines, one idling pattern per phase, with a full drain between
    // phases so that the sender also waits on an empty pipeline.
    target = chars_sent;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = phase_send_idle[ph];
      recv_stall_pct = phase_recv_stall[ph];
      target += PHASE_CHARS;
      while (chars_sent < target) begin
        send_random_line();
      end
      drain_reports();
    end

    // Give any stray result time to show up before judging the run.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && part_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
